@@ rtl/core/lfa_pkg.sv @@
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types, constants and helper functions for the lowest-free
// identifier allocator. The in-use bitmap is kept as rows of ROW_W bits.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int ID_W      = 8;
    localparam int MAP_DEPTH = 256;
    localparam int ROW_W     = 16;
    localparam int ROWS      = MAP_DEPTH / ROW_W;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int BIT_AW    = $clog2(ROW_W);

    // Request operations
    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef logic [ROW_W-1:0]  row_word_t;
    typedef logic [ROW_AW-1:0] row_addr_t;
    typedef logic [BIT_AW-1:0] bit_addr_t;

    // Finished result handed from the controller to the output register
    typedef struct packed {
        logic            valid;
        logic            ok;
        logic [ID_W-1:0] granted_id;
    } lfa_result_t;

    // Bits of a row whose identifier lies at or above the limit
    function automatic row_word_t oor_mask(input row_addr_t row, input int unsigned limit);
        row_word_t   mask;
        int unsigned idx;
        mask = '0;
        for (int b = 0; b < ROW_W; b++) begin
            idx = int'(row) * ROW_W + b;
            mask[b] = (idx >= limit);
        end
        return mask;
    endfunction

    // Rows that hold at least one identifier below the limit
    function automatic logic [ROWS-1:0] row_open_mask(input int unsigned limit);
        logic [ROWS-1:0] mask;
        mask = '0;
        for (int r = 0; r < ROWS; r++) begin
            mask[r] = (r * ROW_W < limit);
        end
        return mask;
    endfunction

endpackage

@@ rtl/core/lowest_free_id_allocator.sv @@
// Flow: an accepted request is held in the controller while its bitmap row is
// read, and its result beat is presented from the output register.
// Requests: a new one is taken only after the previous read-modify-write of
// one bitmap row through the single-read-port RAM has handed its result on.
// Reset: clears the per-row valid and full flags, so every identifier reads
// as free; no clearing pass. A clear request clears the same flags.
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Keeps the set of identifiers in use as a bitmap in RAM and serves allocate,
// release, query and clear requests, one result beat per request.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator #(
    parameter int NUM_IDS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] id
    input  logic [1:0]               s_tuser,   // [1:0] func
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // [7:0] granted_id
    output logic                     m_tuser    // [0] ok
);

    import lfa_pkg::*;

    localparam int ID_LIMIT = (NUM_IDS < MAP_DEPTH) ? NUM_IDS : MAP_DEPTH;

    logic        ram_rd_en;
    row_addr_t   ram_rd_addr;
    row_word_t   ram_rd_data;
    logic        ram_wr_en;
    row_addr_t   ram_wr_addr;
    row_word_t   ram_wr_data;
    lfa_result_t res;
    logic        res_ready;

    logic            m_tvalid_reg;
    logic            m_ok_reg;
    logic [ID_W-1:0] m_id_reg;

    lfa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lfa_ctrl #(
        .ID_LIMIT (ID_LIMIT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_func    (s_tuser),
        .req_id      (s_tdata[ID_W-1:0]),
        .req_ready   (s_tready),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .res         (res),
        .res_ready   (res_ready)
    );

    // Output register: load when empty or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            m_ok_reg <= res.ok;
            m_id_reg <= res.granted_id;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_ok_reg;

endmodule

@@ rtl/core/lfa_ram.sv @@
// ----------------------------------------------------------------------------
// lfa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module lfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfa_ctrl
// Read-modify-write sequencer for the in-use bitmap. Keeps per-row valid and
// full flags in flip-flops, picks the row for an allocate from the full flags,
// then finds the bit inside the row once the RAM word returns.
// ----------------------------------------------------------------------------
module lfa_ctrl #(
    parameter int ID_LIMIT = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request side
    input  logic                      req_valid,
    input  logic [1:0]                req_func,
    input  logic [lfa_pkg::ID_W-1:0]  req_id,
    output logic                      req_ready,
    // bitmap RAM
    output logic                      ram_rd_en,
    output lfa_pkg::row_addr_t        ram_rd_addr,
    input  lfa_pkg::row_word_t        ram_rd_data,
    output logic                      ram_wr_en,
    output lfa_pkg::row_addr_t        ram_wr_addr,
    output lfa_pkg::row_word_t        ram_wr_data,
    // result side
    output lfa_pkg::lfa_result_t      res,
    input  logic                      res_ready
);

    import lfa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [ROWS-1:0] ROW_OPEN = row_open_mask(ID_LIMIT);

    logic            state_reg, state_next;
    logic [ROWS-1:0] row_valid_reg;
    logic [ROWS-1:0] row_full_reg;
    logic [1:0]      func_reg;
    logic [ID_W-1:0] id_reg;
    row_addr_t       row_reg;
    logic            any_free_reg;

    logic [ROWS-1:0] row_avail;
    logic            any_free;
    row_addr_t       free_row;
    logic            accept;
    logic            done;

    row_word_t       word;
    row_word_t       mask;
    row_word_t       occupied;
    bit_addr_t       zero_bit;
    bit_addr_t       rel_bit;
    logic            id_in_range;
    logic            hit;
    logic            do_write;
    logic            do_clear;
    logic            ok;
    logic [ID_W-1:0] granted;
    row_word_t       new_word;

    // Pick the lowest row that still has a free identifier
    always_comb begin
        row_avail = ROW_OPEN & ~row_full_reg;
        any_free  = |row_avail;
        free_row  = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (row_avail[r]) begin
                free_row = row_addr_t'(r);
            end
        end
    end

    assign accept    = (state_reg == ST_IDLE) && req_valid;
    assign req_ready = (state_reg == ST_IDLE);
    assign done      = (state_reg == ST_EXEC) && res_ready;

    // Issue the row read on accept
    assign ram_rd_en   = accept;
    assign ram_rd_addr = (req_func == OP_ALLOCATE) ? free_row
                                                   : req_id[ID_W-1 -: ROW_AW];

    // Modify the returned row
    always_comb begin
        word        = row_valid_reg[row_reg] ? ram_rd_data : '0;
        mask        = oor_mask(row_reg, ID_LIMIT);
        occupied    = word | mask;
        zero_bit    = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!occupied[b]) begin
                zero_bit = bit_addr_t'(b);
            end
        end
        rel_bit     = id_reg[BIT_AW-1:0];
        id_in_range = ({1'b0, id_reg} < (ID_W+1)'(ID_LIMIT));
        hit         = id_in_range && word[rel_bit];
        ok          = 1'b0;
        granted     = '0;
        do_write    = 1'b0;
        do_clear    = 1'b0;
        new_word    = word;
        unique case (func_reg)
            OP_ALLOCATE: begin
                ok       = any_free_reg;
                do_write = any_free_reg;
                new_word = word | (row_word_t'(1) << zero_bit);
                if (any_free_reg) begin
                    granted = {row_reg, zero_bit};
                end
            end
            OP_RELEASE: begin
                ok       = hit;
                do_write = hit;
                new_word = word & ~(row_word_t'(1) << rel_bit);
            end
            OP_QUERY: begin
                ok = hit;
            end
            OP_CLEAR: begin
                ok       = 1'b1;
                do_clear = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign ram_wr_en   = done && do_write;
    assign ram_wr_addr = row_reg;
    assign ram_wr_data = new_word;

    assign res.valid      = (state_reg == ST_EXEC);
    assign res.ok         = ok;
    assign res.granted_id = granted;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end else begin
            state_reg <= state_next;
            // Update row flags as the write-back commits
            if (done && do_clear) begin
                row_valid_reg <= '0;
                row_full_reg  <= '0;
            end else if (done && do_write) begin
                row_valid_reg[row_reg] <= 1'b1;
                row_full_reg[row_reg]  <= &(new_word | mask);
            end
        end
    end

    // Hold the request while its row is read
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= req_func;
            id_reg       <= req_id;
            row_reg      <= ram_rd_addr;
            any_free_reg <= any_free;
        end
    end

endmodule
